// File: design/btn_db_pkg.sv
// ----------------------------------------------------------------------------
// Button debounce package
// Shared constants and types for the debounce and auto-repeat block.
// ----------------------------------------------------------------------------
`default_nettype none

package btn_db_pkg;

  localparam int COUNT_WIDTH = 16;

  localparam logic [7:0] DEBOUNCE_RESET = 8'd10;

  // Division by three of a 16-bit value: (v * 0xAAAB) >> 17.
  localparam logic [32:0] PULSE_RECIP = 33'h0_0000_AAAB;
  localparam int          PULSE_SHIFT = 17;

  localparam int ADDR_WIDTH = 4;

  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_AUTO     = 2'd1;
  localparam logic [1:0] REG_REPEAT   = 2'd2;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_DEBOUNCE = 5'b00010,
    PH_AUTO     = 5'b00100,
    PH_REPEAT   = 5'b01000,
    PH_RELEASE  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic notify;
    logic pressed;
  } result_t;

endpackage

`default_nettype wire

// File: design/button_debounce_autorepeat.sv
// ----------------------------------------------------------------------------
// Button debounce with auto-repeat
// Debounces one active-low button sampled once per millisecond tick and
// reports press, release and auto-repeat events.
// ----------------------------------------------------------------------------
// Each input transfer is one tick carrying the sampled pin level; each tick
// yields exactly one result transfer through the output register, and a new
// tick can be taken every cycle while the skid stage is empty. The rate is set
// by the single registered pass from the tick to the result register, followed
// by a one-entry skid stage that takes one more tick while the output is stalled.
`default_nettype none

module button_debounce_autorepeat #(
  parameter int COUNT_WIDTH = btn_db_pkg::COUNT_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [7:0]                        s_tdata,   // [0] pin_level
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [7:0]                             m_tdata,   // [0] pressed, [1] notify
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [btn_db_pkg::ADDR_WIDTH-1:0] paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  localparam logic [31:0] CountMax = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  function automatic logic [COUNT_WIDTH-1:0] sat_load(input logic [15:0] v);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 > CountMax) begin
      sat_load = '1;
    end else begin
      sat_load = v32[COUNT_WIDTH-1:0];
    end
  endfunction

  logic [7:0]             debounce_ms;
  logic [15:0]            auto_delay_ms;
  logic [15:0]            repeat_ms;
  logic [COUNT_WIDTH-1:0] pulse_load;

  btn_db_pkg::phase_t     phase, phase_next;
  logic [COUNT_WIDTH-1:0] wait_count, wait_count_next;
  logic [COUNT_WIDTH-1:0] pulse_count, pulse_count_next;
  logic                   pulse_armed, pulse_armed_next;
  logic                   pressed_flag, pressed_flag_next;
  logic                   note;

  btn_db_pkg::result_t    out_data, skid_data, result;
  logic                   skid_valid;
  logic                   accept;
  logic                   cfg_write;
  logic [32:0]            div_prod;
  logic [15:0]            div_quot;
  logic [COUNT_WIDTH-1:0] wait_dec, pulse_dec;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign div_prod  = 33'(pwdata[15:0]) * btn_db_pkg::PULSE_RECIP;
  assign div_quot  = div_prod[btn_db_pkg::PULSE_SHIFT +: 16];

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms   <= btn_db_pkg::DEBOUNCE_RESET;
      auto_delay_ms <= '0;
      repeat_ms     <= '0;
      pulse_load    <= COUNT_WIDTH'(1);
    end else if (cfg_write) begin
      case (paddr[3:2])
        btn_db_pkg::REG_DEBOUNCE: debounce_ms <= pwdata[7:0];
        btn_db_pkg::REG_AUTO:     auto_delay_ms <= pwdata[15:0];
        btn_db_pkg::REG_REPEAT: begin
          repeat_ms  <= pwdata[15:0];
          pulse_load <= sat_load((div_quot == 16'd0) ? 16'd1 : div_quot);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      btn_db_pkg::REG_DEBOUNCE: prdata = {24'd0, debounce_ms};
      btn_db_pkg::REG_AUTO:     prdata = {16'd0, auto_delay_ms};
      btn_db_pkg::REG_REPEAT:   prdata = {16'd0, repeat_ms};
      default:                  prdata = '0;
    endcase
  end

  assign wait_dec  = wait_count - COUNT_WIDTH'(1);
  assign pulse_dec = pulse_count - COUNT_WIDTH'(1);

  always_comb begin
    phase_next        = phase;
    wait_count_next   = wait_count;
    pulse_count_next  = pulse_count;
    pulse_armed_next  = pulse_armed;
    pressed_flag_next = pressed_flag;
    note              = 1'b0;

    if (s_tdata[0]) begin
      phase_next        = btn_db_pkg::PH_IDLE;
      wait_count_next   = '0;
      pulse_count_next  = '0;
      pulse_armed_next  = 1'b0;
      pressed_flag_next = 1'b0;
      note              = pressed_flag;
    end else if (phase == btn_db_pkg::PH_IDLE) begin
      phase_next      = btn_db_pkg::PH_DEBOUNCE;
      wait_count_next = sat_load({8'd0, (debounce_ms == 8'd0) ? 8'd1 : debounce_ms});
    end else begin
      if (pulse_armed) begin
        pulse_count_next = pulse_dec;
        if (pulse_dec == '0) begin
          pulse_armed_next  = 1'b0;
          pressed_flag_next = 1'b0;
          note              = pressed_flag;
        end
      end
      if (phase == btn_db_pkg::PH_DEBOUNCE || phase == btn_db_pkg::PH_AUTO ||
          phase == btn_db_pkg::PH_REPEAT) begin
        wait_count_next = wait_dec;
        if (wait_dec == '0) begin
          pressed_flag_next = 1'b1;
          note              = 1'b1;
          if (repeat_ms != 16'd0) begin
            pulse_count_next = pulse_load;
            pulse_armed_next = 1'b1;
          end
          case (phase)
            btn_db_pkg::PH_DEBOUNCE: begin
              if (auto_delay_ms != 16'd0) begin
                wait_count_next = sat_load(auto_delay_ms);
                phase_next      = btn_db_pkg::PH_AUTO;
              end else begin
                phase_next = btn_db_pkg::PH_RELEASE;
              end
            end
            btn_db_pkg::PH_AUTO: begin
              if (repeat_ms != 16'd0) begin
                wait_count_next = sat_load(repeat_ms);
                phase_next      = btn_db_pkg::PH_REPEAT;
              end else begin
                phase_next = btn_db_pkg::PH_RELEASE;
              end
            end
            default: begin
              wait_count_next = sat_load(repeat_ms);
            end
          endcase
        end
      end
    end
  end

  assign result.pressed = pressed_flag_next;
  assign result.notify  = note;

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= btn_db_pkg::PH_IDLE;
      wait_count   <= '0;
      pulse_count  <= '0;
      pulse_armed  <= 1'b0;
      pressed_flag <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      wait_count   <= wait_count_next;
      pulse_count  <= pulse_count_next;
      pulse_armed  <= pulse_armed_next;
      pressed_flag <= pressed_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (accept) begin
      skid_data <= result;
    end
  end

  assign m_tdata = {6'd0, out_data.notify, out_data.pressed};

endmodule

`default_nettype wire

// File: design/btn_db_checker.sv
// ----------------------------------------------------------------------------
// Button debounce checker
// Port-level checks for the debounce and auto-repeat block.
// ----------------------------------------------------------------------------
`default_nettype none

module btn_db_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tvalid,
  input wire logic                              s_tready,
  input wire logic [7:0]                        s_tdata,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [7:0]                        m_tdata,
  input wire logic                              psel,
  input wire logic                              penable,
  input wire logic                              pwrite,
  input wire logic [btn_db_pkg::ADDR_WIDTH-1:0] paddr,
  input wire logic [31:0]                       pwdata,
  input wire logic [31:0]                       prdata,
  input wire logic                              pready
);

  logic last_pressed;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pressed <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      last_pressed <= m_tdata[0];
    end
  end

  // A change of the reported state is always announced.
  a_change_notifies: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && (m_tdata[0] != last_pressed)) |-> m_tdata[1])
    else $error("pressed changed without notify");

  // A release notification only follows a reported press.
  a_release_after_press: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tdata[1] && !m_tdata[0]) |-> last_pressed)
    else $error("release notify without prior press");

  // With no result pending, input is always taken.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind button_debounce_autorepeat btn_db_checker u_btn_db_checker (.*);

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Button debounce with auto-repeat testbench
// Streams pin samples into the block, predicts the pressed and notify
// outputs of every tick, and compares them with each result transfer
// under random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------

module testbench;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 160;
  localparam int HOLD_AFTER     = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [0] pin_level
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;          // [0] pressed, [1] notify
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [btn_db_pkg::ADDR_WIDTH-1:0] paddr = '0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  button_debounce_autorepeat u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  // Predictor copy of the registers and the button state.
  logic [7:0]         cfg_debounce;
  logic [15:0]        cfg_auto;
  logic [15:0]        cfg_repeat;
  btn_db_pkg::phase_t btn_phase;
  logic [15:0]        wait_left;
  logic [15:0]        pulse_left;
  bit                 pulse_armed;
  bit                 pressed_now;

  bit                  pin_queue[$];
  btn_db_pkg::result_t expected_results[$];
  btn_db_pkg::result_t want;
  int      errors = 0;
  int      ticks_taken = 0;
  int      idle_cycles = 0;
  bit      tick_taken = 1'b0;
  bit      calm = 1'b0;
  int      send_gap = 0;
  int      stall_left = 0;
  int      hold_left = 0;
  bit      hold_done = 1'b0;

  function automatic logic [15:0] pulse_length();
    logic [15:0] third;
    third = cfg_repeat / 16'd3;
    return (third == 16'd0) ? 16'd1 : third;
  endfunction

  function automatic btn_db_pkg::result_t tick_button(bit pin);
    btn_db_pkg::result_t r;
    bit                  note;
    note = 1'b0;
    if (pin) begin
      btn_phase   = btn_db_pkg::PH_IDLE;
      wait_left   = '0;
      pulse_left  = '0;
      pulse_armed = 1'b0;
      if (pressed_now) begin
        pressed_now = 1'b0;
        note = 1'b1;
      end
    end else if (btn_phase == btn_db_pkg::PH_IDLE) begin
      btn_phase = btn_db_pkg::PH_DEBOUNCE;
      wait_left = (cfg_debounce == 8'd0) ? 16'd1 : {8'd0, cfg_debounce};
    end else begin
      if (pulse_armed) begin
        pulse_left = pulse_left - 16'd1;
        if (pulse_left == 16'd0) begin
          pulse_armed = 1'b0;
          if (pressed_now) begin
            pressed_now = 1'b0;
            note = 1'b1;
          end
        end
      end
      if (btn_phase == btn_db_pkg::PH_DEBOUNCE || btn_phase == btn_db_pkg::PH_AUTO ||
          btn_phase == btn_db_pkg::PH_REPEAT) begin
        wait_left = wait_left - 16'd1;
        if (wait_left == 16'd0) begin
          if (btn_phase != btn_db_pkg::PH_RELEASE) begin
            pressed_now = 1'b1;
            note = 1'b1;
            if (cfg_repeat != 16'd0) begin
              pulse_left  = pulse_length();
              pulse_armed = 1'b1;
            end
          end
          case (btn_phase)
            btn_db_pkg::PH_DEBOUNCE: begin
              if (cfg_auto != 16'd0) begin
                wait_left = cfg_auto;
                btn_phase = btn_db_pkg::PH_AUTO;
              end else begin
                btn_phase = btn_db_pkg::PH_RELEASE;
              end
            end
            btn_db_pkg::PH_AUTO: begin
              if (cfg_repeat != 16'd0) begin
                wait_left = cfg_repeat;
                btn_phase = btn_db_pkg::PH_REPEAT;
              end else begin
                btn_phase = btn_db_pkg::PH_RELEASE;
              end
            end
            btn_db_pkg::PH_REPEAT: begin
              wait_left = cfg_repeat;
            end
            default: begin
            end
          endcase
        end
      end
    end
    r.pressed = pressed_now;
    r.notify  = note;
    return r;
  endfunction

  // Sender of pin samples.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || tick_taken) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pin_queue.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, pin_queue.pop_front()};
        if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 18);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver of results, with one long hold-off once traffic is flowing.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (!hold_done && ticks_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 17);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Prediction on each input transfer, checking on each output transfer.
  always @(posedge clk) begin
    tick_taken <= s_tvalid && s_tready && !rst;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result pressed=%0b notify=%0b",
                   $time, m_tdata[0], m_tdata[1]);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[0] !== want.pressed) begin
            $display("%0t: pressed expected %0b, got %0b", $time, want.pressed, m_tdata[0]);
            errors++;
          end
          if (m_tdata[1] !== want.notify) begin
            $display("%0t: notify expected %0b, got %0b", $time, want.notify, m_tdata[1]);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        expected_results.insert(expected_results.size(), tick_button(s_tdata[0]));
        ticks_taken++;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
          $display("FAILED: results differ");
          $finish;
        end
      end
    end
  end

  task automatic add_pin(input bit level);
    pin_queue.insert(pin_queue.size(), level);
  endtask

  task automatic settle();
    while (pin_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      btn_db_pkg::REG_DEBOUNCE: cfg_debounce = value[7:0];
      btn_db_pkg::REG_AUTO:     cfg_auto     = value[15:0];
      btn_db_pkg::REG_REPEAT:   cfg_repeat   = value[15:0];
      default: begin
      end
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== value) begin
      $display("%0t: register %0d read expected %0h, got %0h", $time, idx, value, prdata);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_setting(input int db, input int ad, input int rp);
    settle();
    program_reg(btn_db_pkg::REG_DEBOUNCE, db);
    program_reg(btn_db_pkg::REG_AUTO, ad);
    program_reg(btn_db_pkg::REG_REPEAT, rp);
  endtask

  // Mostly press-and-release runs of random length, the rest random noise.
  task automatic queue_presses(input int count);
    int added;
    int reach;
    int len;
    added = 0;
    reach = cfg_debounce + cfg_auto + 3 * cfg_repeat + 4;
    if (reach > 60) reach = 60;
    while (added < count) begin
      if ($urandom_range(0, 3) == 0) begin
        len = $urandom_range(1, 6);
        repeat (len) add_pin(1'($urandom_range(0, 1)));
        added += len;
      end else begin
        len = $urandom_range(1, reach);
        repeat (len) add_pin(1'b0);
        add_pin(1'b1);
        added += len + 1;
      end
    end
  endtask

  initial begin
    cfg_debounce = btn_db_pkg::DEBOUNCE_RESET;
    cfg_auto     = '0;
    cfg_repeat   = '0;
    btn_phase    = btn_db_pkg::PH_IDLE;
    wait_left    = '0;
    pulse_left   = '0;
    pulse_armed  = 1'b0;
    pressed_now  = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: release while idle, a full press, a quick re-press.
    add_pin(1'b1);
    repeat (12) add_pin(1'b0);
    add_pin(1'b1);
    repeat (3) add_pin(1'b0);
    add_pin(1'b1);
    add_pin(1'b1);
    repeat (2) add_pin(1'b0);
    add_pin(1'b1);

    apply_setting(0, 3, 2);
    queue_presses(200);
    apply_setting(1, 1, 1);
    queue_presses(200);
    apply_setting(255, 65535, 65535);
    repeat (260) add_pin(1'b0);
    add_pin(1'b1);
    queue_presses(40);
    apply_setting(3, 0, 6);
    queue_presses(200);
    apply_setting(2, 5, 0);
    queue_presses(200);
    for (int k = 0; k < 4; k++) begin
      apply_setting($urandom_range(0, 12), $urandom_range(0, 20), $urandom_range(0, 20));
      if (k == 3) calm = 1'b1;
      queue_presses(150);
    end

    settle();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: files.f
design/btn_db_pkg.sv
design/button_debounce_autorepeat.sv
design/btn_db_checker.sv
verif/testbench.sv
